// ----- sv/wspi_pkg.sv -----
// Shared types and constants of the wheel speed PI controller.
package wspi_pkg;

  typedef enum logic [0:0] {
    KIND_TARGET = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    REG_PROP_GAIN  = 1'b0,
    REG_INTEG_GAIN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic        wheel;
    logic [15:0] data;
  } item_t;

  localparam int ERR_LIMIT   = 100;
  localparam int DRIVE_LIMIT = 255;

  localparam logic [7:0] PROP_GAIN_RST  = 8'd1;
  localparam logic [7:0] INTEG_GAIN_RST = 8'd0;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

endpackage

// ----- sv/wspi_front.sv -----
// Front end: accepts input beats, drops foreign wheels, packs queue entries.
module wspi_front #(
  parameter int NUM_WHEELS = 2
) (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            kind_i,
  input  logic            wheel_i,
  input  logic [15:0]     target_speed_i,
  input  logic [15:0]     encoder_count_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output wspi_pkg::item_t q_item_o
);
  import wspi_pkg::*;

  logic  wheel_ok;
  kind_e kind;

  assign kind       = kind_e'(kind_i);
  assign wheel_ok   = 32'(wheel_i) < NUM_WHEELS;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && wheel_ok;

  always_comb begin
    q_item_o.kind  = kind;
    q_item_o.wheel = wheel_i;
    unique case (kind)
      KIND_TARGET: q_item_o.data = target_speed_i;
      KIND_TICK:   q_item_o.data = encoder_count_i;
      default:     q_item_o.data = encoder_count_i;
    endcase
  end

endmodule

// ----- sv/wspi_queue.sv -----
// Short queue between the front end and the control back end.
module wspi_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wspi_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output wspi_pkg::item_t head_o
);
  import wspi_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o       = cnt_q == QCNT_W'(QDEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");

endmodule

// ----- sv/wspi_back.sv -----
// Back end: per-wheel state, gain registers and the three-stage PI datapath.
module wspi_back #(
  parameter int NUM_WHEELS   = 2,
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  wspi_pkg::item_t   head_i,
  output logic              pop_o,
  input  logic              cfg_we_i,
  input  wspi_pkg::reg_idx_e cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              wheel_out_o,
  output logic signed [15:0] measured_speed_o,
  output logic signed [7:0] integral_out_o,
  output logic signed [8:0] drive_o
);
  import wspi_pkg::*;

  localparam int IdxW = NUM_WHEELS > 1 ? $clog2(NUM_WHEELS) : 1;
  localparam int SpW  = COUNTER_BITS > 16 ? COUNTER_BITS : 16;
  localparam int ErW  = SpW + 1;
  localparam int DrW  = (SpW > 17 ? SpW : 17) + 3;

  logic [COUNTER_BITS-1:0] last_q  [NUM_WHEELS];
  logic signed [7:0]       integ_q [NUM_WHEELS];
  logic signed [15:0]      tgt_q   [NUM_WHEELS];
  logic [7:0]              kp_q, ki_q;

  logic                    adv;
  logic [IdxW-1:0]         idx;
  logic [COUNTER_BITS-1:0] now, diff;
  logic signed [SpW-1:0]   speed;
  logic signed [ErW-1:0]   err_full;
  logic signed [7:0]       err_c, integ_c;
  logic signed [8:0]       isum;

  logic                    s1_v_q, s1_wheel_q;
  logic signed [SpW-1:0]   s1_speed_q;
  logic signed [7:0]       s1_err_q, s1_integ_q;

  logic                    s2_v_q, s2_wheel_q;
  logic signed [SpW-1:0]   s2_speed_q;
  logic signed [7:0]       s2_err_q, s2_integ_q;
  logic signed [16:0]      s2_pp_q, s2_pi_q, pp_d, pi_d;

  logic signed [DrW-1:0]   dsum;
  logic signed [8:0]       drive_c;
  logic                    o_v_q;

  assign adv   = !o_v_q || !out_stall_i;
  assign pop_o = head_valid_i && adv;
  assign idx   = IdxW'(head_i.wheel);

  always_comb begin
    now      = COUNTER_BITS'(head_i.data);
    diff     = now - last_q[idx];
    speed    = SpW'($signed(diff));
    err_full = ErW'(tgt_q[idx]) - ErW'(speed);
    if (err_full > ErW'(ERR_LIMIT)) begin
      err_c = 8'(ERR_LIMIT);
    end else if (err_full < -ErW'(ERR_LIMIT)) begin
      err_c = -8'(ERR_LIMIT);
    end else begin
      err_c = 8'(err_full);
    end
    isum = 9'(integ_q[idx]) + 9'(err_c);
    if (isum > 9'(ERR_LIMIT)) begin
      integ_c = 8'(ERR_LIMIT);
    end else if (isum < -9'(ERR_LIMIT)) begin
      integ_c = -8'(ERR_LIMIT);
    end else begin
      integ_c = 8'(isum);
    end
  end

  always_comb begin
    pp_d = $signed({1'b0, kp_q}) * s1_err_q;
    pi_d = $signed({1'b0, ki_q}) * s1_integ_q;
  end

  always_comb begin
    dsum = DrW'(s2_speed_q) + DrW'(s2_err_q) + DrW'(s2_pp_q) + DrW'(s2_pi_q);
    if (dsum > DrW'(DRIVE_LIMIT)) begin
      drive_c = 9'(DRIVE_LIMIT);
    end else if (dsum < -DrW'(DRIVE_LIMIT)) begin
      drive_c = -9'(DRIVE_LIMIT);
    end else begin
      drive_c = 9'(dsum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= PROP_GAIN_RST;
      ki_q <= INTEG_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:  kp_q <= cfg_data_i;
        REG_INTEG_GAIN: ki_q <= cfg_data_i;
        default:        kp_q <= kp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_q[i]  <= '0;
        integ_q[i] <= '0;
        tgt_q[i]   <= '0;
      end
    end else if (pop_o) begin
      unique case (head_i.kind)
        KIND_TARGET: tgt_q[idx] <= $signed(head_i.data);
        KIND_TICK: begin
          last_q[idx]  <= now;
          integ_q[idx] <= integ_c;
        end
        default: tgt_q[idx] <= tgt_q[idx];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= pop_o && head_i.kind == KIND_TICK;
      s2_v_q <= s1_v_q;
      o_v_q  <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_wheel_q       <= head_i.wheel;
      s1_speed_q       <= speed;
      s1_err_q         <= err_c;
      s1_integ_q       <= integ_c;
      s2_wheel_q       <= s1_wheel_q;
      s2_speed_q       <= s1_speed_q;
      s2_err_q         <= s1_err_q;
      s2_integ_q       <= s1_integ_q;
      s2_pp_q          <= pp_d;
      s2_pi_q          <= pi_d;
      wheel_out_o      <= s2_wheel_q;
      measured_speed_o <= s2_speed_q[15:0];
      integral_out_o   <= s2_integ_q;
      drive_o          <= drive_c;
    end
  end

  assign out_valid_o = o_v_q;

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_integ_q <= 8'sd100 && s1_integ_q >= -8'sd100))
    else $error("integral outside clamp");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> (drive_o <= 9'sd255 && drive_o >= -9'sd255))
    else $error("drive outside clamp");

endmodule

// ----- sv/wheel_speed_pi_controller_top.sv -----
// Top level of the wheel speed PI controller.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o    | kind_i wheel_i target_speed_i encoder_count_i
//  cfg     | cfg_we_i                   | cfg_idx_i cfg_data_i
//  out     | out_valid_o / out_stall_i  | wheel_out_o measured_speed_o integral_out_o drive_o
//
// One input beat per cycle sustained while out_stall_i is low. A tick result passes through the
// 4-entry queue and then the three back-end stages (state update, gain multiply, sum and
// clamp). Target beats and foreign wheels give no result.
// Reset clears wheel state, sets prop gain to 1 and integral gain to 0.
// A stalled result freezes the back end; the queue then fills and raises in_stall_o.
module wheel_speed_pi_controller_top #(
  parameter int NUM_WHEELS   = 2,
  parameter int COUNTER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic               wheel_i,
  input  logic signed [15:0] target_speed_i,
  input  logic [15:0]        encoder_count_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               wheel_out_o,
  output logic signed [15:0] measured_speed_o,
  output logic signed [7:0]  integral_out_o,
  output logic signed [8:0]  drive_o
);
  import wspi_pkg::*;

  logic  q_full, q_push, q_pop, q_head_v;
  item_t q_item, q_head;

  wspi_front #(
    .NUM_WHEELS(NUM_WHEELS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .wheel_i        (wheel_i),
    .target_speed_i (target_speed_i),
    .encoder_count_i(encoder_count_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_item)
  );

  wspi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .item_i      (q_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(q_head_v),
    .head_o      (q_head)
  );

  wspi_back #(
    .NUM_WHEELS  (NUM_WHEELS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (q_head_v),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (reg_idx_e'(cfg_idx_i)),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .wheel_out_o     (wheel_out_o),
    .measured_speed_o(measured_speed_o),
    .integral_out_o  (integral_out_o),
    .drive_o         (drive_o)
  );

endmodule

// ----- tb/wheel_speed_pi_controller_top_test.sv -----
// Self-checking testbench of the wheel speed PI controller: directed table, then random beats.
module wheel_speed_pi_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wspi_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 150;
  localparam int SETTLE_CYCLES   = 12;
  localparam int DRAIN_LIMIT     = 4000;

  typedef struct {
    logic               wheel;
    logic signed [15:0] speed;
    logic signed [7:0]  integ;
    logic signed [8:0]  drive;
  } wheel_result_t;

  typedef struct {
    kind_e         kind;
    logic          wheel;
    logic [15:0]   data;
    bit            typed;
    wheel_result_t want;
  } beat_t;

  localparam wheel_result_t NO_TYPED = '{1'b0, 16'sd0, 8'sd0, 9'sd0};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               kind_i;
  logic               wheel_i;
  logic signed [15:0] target_speed_i;
  logic [15:0]        encoder_count_i;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [7:0]         cfg_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               wheel_out_o;
  logic signed [15:0] measured_speed_o;
  logic signed [7:0]  integral_out_o;
  logic signed [8:0]  drive_o;

  logic [15:0]     last_count_q [2];
  int              integ_acc [2];
  int              target_spd [2];
  logic [7:0]      kp;
  logic [7:0]      ki;
  wheel_result_t   expected_results [$];
  int              fail_count = 0;
  int              cycle_count = 0;
  int              quiet_left = 0;
  bit              hold_req = 1'b0;
  bit              calm = 1'b0;

  beat_t directed_beats [25] = '{
    '{KIND_TICK,   1'b0, 16'h0000, 1'b1, '{1'b0, 16'sd0,     8'sd0,    9'sd0}},
    '{KIND_TICK,   1'b1, 16'h7FFF, 1'b1, '{1'b1, 16'sh7FFF, -8'sd100,  9'sd255}},
    '{KIND_TICK,   1'b1, 16'hFFFF, 1'b1, '{1'b1, 16'sh8000,  8'sd0,   -9'sd255}},
    '{KIND_TARGET, 1'b0, 16'h7FFF, 1'b0, NO_TYPED},
    '{KIND_TARGET, 1'b1, 16'h8000, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b0, 16'h0000, 1'b1, '{1'b0, 16'sd0,     8'sd100,  9'sd200}},
    '{KIND_TICK,   1'b1, 16'hFFFF, 1'b1, '{1'b1, 16'sd0,    -8'sd100, -9'sd200}},
    '{KIND_TICK,   1'b0, 16'hFFFF, 1'b1, '{1'b0, -16'sd1,    8'sd100,  9'sd199}},
    '{KIND_TICK,   1'b0, 16'h0000, 1'b1, '{1'b0, 16'sd1,     8'sd100,  9'sd201}},
    '{KIND_TARGET, 1'b0, 16'h0005, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b0, 16'h0005, 1'b1, '{1'b0, 16'sd5,     8'sd100,  9'sd5}},
    '{KIND_TARGET, 1'b1, 16'h000A, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b1, 16'h0003, 1'b1, '{1'b1, 16'sd4,    -8'sd94,   9'sd16}},
    '{KIND_TARGET, 1'b0, 16'hFF9C, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b0, 16'h0005, 1'b1, '{1'b0, 16'sd0,     8'sd0,   -9'sd200}},
    '{KIND_TARGET, 1'b1, 16'h0096, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b1, 16'h0010, 1'b0, NO_TYPED},
    '{KIND_TARGET, 1'b0, 16'hFFF6, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b0, 16'hFF00, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b1, 16'h1234, 1'b0, NO_TYPED},
    '{KIND_TARGET, 1'b1, 16'h0001, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b1, 16'h1235, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b0, 16'hAAAA, 1'b0, NO_TYPED},
    '{KIND_TICK,   1'b1, 16'h5555, 1'b0, NO_TYPED}
  };

  wheel_speed_pi_controller_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .wheel_i         (wheel_i),
    .target_speed_i  (target_speed_i),
    .encoder_count_i (encoder_count_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .wheel_out_o     (wheel_out_o),
    .measured_speed_o(measured_speed_o),
    .integral_out_o  (integral_out_o),
    .drive_o         (drive_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int saturate(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic wheel_result_t advance_wheel(logic w, logic [15:0] cnt);
    wheel_result_t r;
    logic [15:0]   diff;
    int            speed;
    int            err;
    int            acc;
    int            drv;
    diff = cnt - last_count_q[w];
    last_count_q[w] = cnt;
    speed = int'($signed(diff));
    err = saturate(target_spd[w] - speed, ERR_LIMIT);
    acc = saturate(integ_acc[w] + err, ERR_LIMIT);
    integ_acc[w] = acc;
    drv = saturate(speed + err + int'(kp) * err + int'(ki) * acc, DRIVE_LIMIT);
    r.wheel = w;
    r.speed = diff;
    r.integ = acc[7:0];
    r.drive = drv[8:0];
    return r;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    delta;
    b.typed = 1'b0;
    b.want = NO_TYPED;
    b.wheel = 1'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      b.kind = KIND_TARGET;
      case ($urandom_range(0, 9))
        0, 1:    b.data = 16'($urandom);
        2, 3, 4: b.data = 16'(int'($urandom_range(0, 6000)) - 3000);
        default: b.data = 16'(int'($urandom_range(0, 300)) - 150);
      endcase
    end else begin
      b.kind = KIND_TICK;
      case ($urandom_range(0, 9))
        0:       delta = int'($urandom);
        1, 2:    delta = int'($urandom_range(0, 600)) - 300;
        default: delta = target_spd[b.wheel] + int'($urandom_range(0, 80)) - 40;
      endcase
      b.data = last_count_q[b.wheel] + 16'(delta);
    end
    return b;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_beat(input beat_t b);
    wheel_result_t r;
    in_valid_i <= 1'b1;
    kind_i     <= b.kind;
    wheel_i    <= b.wheel;
    if (b.kind == KIND_TARGET) begin
      target_speed_i  <= b.data;
      encoder_count_i <= 16'($urandom);
    end else begin
      target_speed_i  <= 16'($urandom);
      encoder_count_i <= b.data;
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (b.kind == KIND_TARGET) begin
      target_spd[b.wheel] = int'($signed(b.data));
    end else begin
      r = advance_wheel(b.wheel, b.data);
      expected_results.push_back(b.typed ? b.want : r);
    end
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (!calm) begin
      if (quiet_left > 0) begin
        quiet_left--;
      end else begin
        case ($urandom_range(0, 9))
          0:       quiet_left = $urandom_range(20, 80);
          1, 2, 3: n = $urandom_range(1, 14);
          default: ;
        endcase
      end
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gains(input logic [7:0] p_gain, input logic [7:0] i_gain);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PROP_GAIN;
    cfg_data_i <= p_gain;
    @(posedge clk_i);
    cfg_idx_i  <= REG_INTEG_GAIN;
    cfg_data_i <= i_gain;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    kp = p_gain;
    ki = i_gain;
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(20, 80)) @(posedge clk_i);
          1, 2, 3: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clk_i);
            out_stall_i <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    wheel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual wheel %0d speed %0d drive %0d",
                 $time, wheel_out_o, measured_speed_o, drive_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("wheel_out", {31'd0, want.wheel}, {31'd0, wheel_out_o});
        compare_field("measured_speed", want.speed, measured_speed_o);
        compare_field("integral_out", want.integ, integral_out_o);
        compare_field("drive", want.drive, drive_o);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    beat_t b;
    int    p;
    int    n;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    kind_i          <= KIND_TARGET;
    wheel_i         <= 1'b0;
    target_speed_i  <= '0;
    encoder_count_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_PROP_GAIN;
    cfg_data_i      <= '0;
    kp = PROP_GAIN_RST;
    ki = INTEG_GAIN_RST;
    for (n = 0; n < 2; n++) begin
      last_count_q[n] = '0;
      integ_acc[n] = 0;
      target_spd[n] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_beats[k]) begin
      sender_gap();
      send_beat(directed_beats[k]);
    end
    drain_and_settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      calm = (p == NUM_PHASES - 1);
      case (p)
        0: write_gains(8'd0, 8'd0);
        1: write_gains(8'd255, 8'd255);
        2: write_gains(8'd255, 8'd0);
        3: write_gains(8'd0, 8'd255);
        default: begin
          if (p % 2 == 1) write_gains(8'($urandom), 8'($urandom));
          else write_gains(8'($urandom_range(0, 6)), 8'($urandom_range(0, 3)));
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == 40) hold_req = 1'b1;
        if (p == 4 && n == 95) drain_and_settle();
        sender_gap();
        b = random_beat();
        send_beat(b);
      end
      drain_and_settle();
    end

    if (expected_results.size() != 0) begin
      $display("%0t: missing beats, expected %0d more, actual 0",
               $time, expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wspi_pkg.sv
sv/wspi_front.sv
sv/wspi_queue.sv
sv/wspi_back.sv
sv/wheel_speed_pi_controller_top.sv
tb/wheel_speed_pi_controller_top_test.sv
